### hw/rtl/bms_pkg.sv
package bms_pkg;

  localparam int NOTE_DEPTH = 256;
  localparam int NOTE_AW    = $clog2(NOTE_DEPTH);
  localparam int POS_W      = $clog2(NOTE_DEPTH + 1);

  localparam int FREQ_W     = 16;
  localparam int NDIV_W     = 7;
  localparam int ENTRY_W    = FREQ_W + NDIV_W;
  localparam int ELAPSED_W  = 24;
  localparam int REP_W      = 16;
  localparam int TEMPO_W    = 10;
  localparam int MLEN_W     = 9;
  localparam int CFG_W      = 24;
  localparam int WHOLE_W    = 18;
  localparam int LEN_W      = WHOLE_W + 1;
  localparam int SCALE_W    = 16;
  localparam int DIV_CNT_W  = $clog2(WHOLE_W);
  localparam int MUL_CNT_W  = $clog2(SCALE_W);

  localparam logic [WHOLE_W-1:0] WHOLE_NUM   = WHOLE_W'(240000);
  localparam logic [SCALE_W-1:0] TONE_SCALE  = SCALE_W'(58982);
  localparam logic [NDIV_W-1:0]  QUARTER_DIV = NDIV_W'(4);

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_BEEP   = 3'd1,
    OP_MELODY = 3'd2,
    OP_STOP   = 3'd3,
    OP_WRITE  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_GAP    = 2'd1,
    MODE_BEEP   = 2'd2,
    MODE_MELODY = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    CFG_BEEP_FREQ = 3'd0,
    CFG_BEEP_ON   = 3'd1,
    CFG_BEEP_GAP  = 3'd2,
    CFG_REPEATS   = 3'd3,
    CFG_INIT_GAP  = 3'd4,
    CFG_TEMPO     = 3'd5,
    CFG_MEL_LEN   = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_WHOLE,
    ST_NOTE_CHECK,
    ST_NOTE_READ,
    ST_DIV_NOTE,
    ST_MUL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic ready;
    logic div_start;
    logic mul_start;
    logic mem_re;
    logic out_load;
  } seq_ctl_t;

endpackage

### hw/rtl/bms_notes.sv
module bms_notes import bms_pkg::*; (
  input  logic               clk,
  input  logic               we,
  input  logic [NOTE_AW-1:0] waddr,
  input  logic [ENTRY_W-1:0] wdata,
  input  logic               re,
  input  logic [NOTE_AW-1:0] raddr,
  output logic [ENTRY_W-1:0] rdata
);

  logic [ENTRY_W-1:0] mem [NOTE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/bms_div.sv
// restoring divider, one quotient bit per cycle
module bms_div import bms_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [WHOLE_W-1:0] dividend,
  input  logic [TEMPO_W-1:0] divisor,
  output logic               done,
  output logic [WHOLE_W-1:0] quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [WHOLE_W-1:0]   q;
  logic [TEMPO_W-1:0]   r;
  logic [TEMPO_W-1:0]   d;
  logic [TEMPO_W:0]     trial;
  logic [TEMPO_W:0]     diff;
  logic                 ge;

  assign trial    = {r, q[WHOLE_W-1]};
  assign diff     = trial - {1'b0, d};
  assign ge       = trial >= {1'b0, d};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(WHOLE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      r <= '0;
      d <= divisor;
    end else if (busy) begin
      r <= ge ? diff[TEMPO_W-1:0] : trial[TEMPO_W-1:0];
      q <= {q[WHOLE_W-2:0], ge};
    end
  end

endmodule

### hw/rtl/bms_mul.sv
// shift-add scaling by TONE_SCALE, one constant bit per cycle; product >> SCALE_W
module bms_mul import bms_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [LEN_W-1:0] len,
  output logic             done,
  output logic [LEN_W-1:0] product
);

  logic                 busy;
  logic [MUL_CNT_W-1:0] cnt;
  logic [LEN_W-1:0]     m;
  logic [LEN_W:0]       hi;
  logic [SCALE_W-1:0]   lo;
  logic [LEN_W+1:0]     sum;

  assign sum     = {1'b0, hi} + (lo[0] ? (LEN_W+2)'(m) : '0);
  assign product = hi[LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + MUL_CNT_W'(1);
        if (cnt == MUL_CNT_W'(SCALE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      m  <= len;
      hi <= '0;
      lo <= TONE_SCALE;
    end else if (busy) begin
      hi <= sum[LEN_W+1:1];
      lo <= {sum[0], lo[SCALE_W-1:1]};
    end
  end

endmodule

### hw/rtl/beep_and_melody_sequencer.sv
// channel   | group                  | contents
// ----------+------------------------+------------------------------------------
// command   | s_tvalid/s_tready      | s_tuser: opcode; s_tdata: slot, freq, div
// status    | m_tvalid/m_tready      | m_tdata: one status transaction per command
// config    | cfg_we/cfg_index       | cfg_data, written while cfg_we is high
//
// Tick, beep start, stop and note write go from accept straight to status.
// Note start runs the end check, the store read, the serial divide and the serial
// multiply in turn, with a handoff between each; melody start first adds the serial
// tempo divide and its handoff. Commands are taken only in the idle state; a pending
// status transaction holds completion, and with it the next command.
// rst is synchronous, active high.
module beep_and_melody_sequencer import bms_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [31:0]      s_tdata,   // note_slot, note_frequency, note_divider
  input  logic [2:0]       s_tuser,   // opcode
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [47:0]      m_tdata,   // tone_on, tone_frequency, tone_limit_ms,
                                      // mode, current_note
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  state_t   state, state_next;
  seq_ctl_t ctl;

  logic [FREQ_W-1:0]    beep_frequency;
  logic [ELAPSED_W-1:0] beep_on_ms;
  logic [ELAPSED_W-1:0] beep_gap_ms;
  logic [REP_W-1:0]     beep_repeats;
  logic                 beep_initial_gap;
  logic [TEMPO_W-1:0]   tempo_bpm;
  logic [MLEN_W-1:0]    melody_length;

  mode_t                mode_reg;
  logic [ELAPSED_W-1:0] elapsed_ms;
  logic [REP_W-1:0]     repeats_left;
  logic [WHOLE_W-1:0]   whole_note_ms;
  logic [POS_W-1:0]     note_pos;
  logic [LEN_W-1:0]     note_wait_ms;
  logic                 tone_active;
  logic [FREQ_W-1:0]    tone_freq_reg;
  logic [LEN_W-1:0]     tone_limit_reg;
  logic [FREQ_W-1:0]    note_freq;
  logic                 note_dotted;

  op_t                  op;
  logic                 s_accept;
  logic [ELAPSED_W-1:0] elapsed_inc;
  logic                 gap_hit, on_hit, note_hit;
  logic [REP_W-1:0]     rep_dec;
  logic [POS_W-1:0]     eff_len;
  logic                 melody_end;
  logic [TEMPO_W-1:0]   tempo_eff;

  logic [ENTRY_W-1:0]   rd_entry;
  logic [NDIV_W-1:0]    ndiv, ndiv_mag, ndiv_eff;

  logic [WHOLE_W-1:0]   div_dividend;
  logic [TEMPO_W-1:0]   div_divisor;
  logic                 div_done;
  logic [WHOLE_W-1:0]   div_q;
  logic [LEN_W-1:0]     note_len;
  logic                 mul_done;
  logic [LEN_W-1:0]     mul_p;

  assign op          = op_t'(s_tuser);
  assign s_tready    = ctl.ready;
  assign s_accept    = s_tvalid && ctl.ready;

  assign elapsed_inc = (elapsed_ms == '1) ? elapsed_ms : elapsed_ms + ELAPSED_W'(1);
  assign gap_hit     = elapsed_inc >= beep_gap_ms;
  assign on_hit      = elapsed_inc >= beep_on_ms;
  assign note_hit    = elapsed_inc >= ELAPSED_W'(note_wait_ms);
  assign rep_dec     = repeats_left - REP_W'(1);
  assign eff_len     = (32'(melody_length) > NOTE_DEPTH) ? POS_W'(NOTE_DEPTH)
                                                         : POS_W'(melody_length);
  assign melody_end  = note_pos >= eff_len;
  assign tempo_eff   = (tempo_bpm == '0) ? TEMPO_W'(1) : tempo_bpm;

  // note divider: magnitude of a signed value, zero means quarter, negative means dotted
  assign ndiv     = rd_entry[ENTRY_W-1:FREQ_W];
  assign ndiv_mag = ndiv[NDIV_W-1] ? NDIV_W'(-ndiv) : ndiv;
  assign ndiv_eff = (ndiv == '0) ? QUARTER_DIV : ndiv_mag;

  assign div_dividend = (state == ST_IDLE) ? WHOLE_NUM : whole_note_ms;
  assign div_divisor  = (state == ST_IDLE) ? tempo_eff : TEMPO_W'(ndiv_eff);
  assign note_len     = LEN_W'(div_q) + (note_dotted ? LEN_W'(div_q[WHOLE_W-1:1]) : '0);

  bms_notes u_notes (
    .clk   (clk),
    .we    (s_accept && op == OP_WRITE),
    .waddr (NOTE_AW'(s_tdata[7:0])),
    .wdata ({s_tdata[30:24], s_tdata[23:8]}),
    .re    (ctl.mem_re),
    .raddr (note_pos[NOTE_AW-1:0]),
    .rdata (rd_entry)
  );

  bms_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  bms_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (ctl.mul_start),
    .len     (note_len),
    .done    (mul_done),
    .product (mul_p)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (op == OP_MELODY) begin
            state_next = ST_DIV_WHOLE;
          end else if (op == OP_TICK && mode_reg == MODE_MELODY && note_hit) begin
            state_next = ST_NOTE_CHECK;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_DIV_WHOLE:  if (div_done) state_next = ST_NOTE_CHECK;
      ST_NOTE_CHECK: state_next = melody_end ? ST_DONE : ST_NOTE_READ;
      ST_NOTE_READ:  state_next = ST_DIV_NOTE;
      ST_DIV_NOTE:   if (div_done) state_next = ST_MUL;
      ST_MUL:        if (mul_done) state_next = ST_DONE;
      ST_DONE:       if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state)
      ST_IDLE: begin
        ctl.ready     = 1'b1;
        ctl.div_start = s_tvalid && op == OP_MELODY;
      end
      ST_NOTE_CHECK: ctl.mem_re    = !melody_end;
      ST_NOTE_READ:  ctl.div_start = 1'b1;
      ST_DIV_NOTE:   ctl.mul_start = div_done;
      ST_DONE:       ctl.out_load  = !m_tvalid || m_tready;
      default:       ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      beep_frequency   <= '0;
      beep_on_ms       <= '0;
      beep_gap_ms      <= '0;
      beep_repeats     <= REP_W'(1);
      beep_initial_gap <= 1'b0;
      tempo_bpm        <= TEMPO_W'(120);
      melody_length    <= '0;
      mode_reg         <= MODE_IDLE;
      elapsed_ms       <= '0;
      repeats_left     <= '0;
      whole_note_ms    <= '0;
      note_pos         <= '0;
      note_wait_ms     <= '0;
      tone_active      <= 1'b0;
      tone_freq_reg    <= '0;
      tone_limit_reg   <= '0;
      m_tvalid         <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_BEEP_FREQ: beep_frequency   <= cfg_data[FREQ_W-1:0];
          CFG_BEEP_ON:   beep_on_ms       <= cfg_data[ELAPSED_W-1:0];
          CFG_BEEP_GAP:  beep_gap_ms      <= cfg_data[ELAPSED_W-1:0];
          CFG_REPEATS:   beep_repeats     <= cfg_data[REP_W-1:0];
          CFG_INIT_GAP:  beep_initial_gap <= cfg_data[0];
          CFG_TEMPO:     tempo_bpm        <= cfg_data[TEMPO_W-1:0];
          CFG_MEL_LEN:   melody_length    <= cfg_data[MLEN_W-1:0];
          default: ;
        endcase
      end

      if (s_accept) begin
        unique case (op)
          OP_TICK: begin
            unique case (mode_reg)
              MODE_IDLE: ;
              MODE_GAP: begin
                if (gap_hit) begin
                  mode_reg       <= MODE_BEEP;
                  elapsed_ms     <= '0;
                  tone_active    <= 1'b1;
                  tone_freq_reg  <= beep_frequency;
                  tone_limit_reg <= '0;
                end else begin
                  elapsed_ms <= elapsed_inc;
                end
              end
              MODE_BEEP: begin
                if (on_hit) begin
                  tone_active    <= 1'b0;
                  tone_freq_reg  <= '0;
                  tone_limit_reg <= '0;
                  repeats_left   <= rep_dec;
                  if (rep_dec != '0) begin
                    mode_reg   <= MODE_GAP;
                    elapsed_ms <= '0;
                  end else begin
                    mode_reg   <= MODE_IDLE;
                    elapsed_ms <= elapsed_inc;
                  end
                end else begin
                  elapsed_ms <= elapsed_inc;
                end
              end
              MODE_MELODY: begin
                elapsed_ms <= elapsed_inc;
                if (note_hit) begin
                  tone_active    <= 1'b0;
                  tone_freq_reg  <= '0;
                  tone_limit_reg <= '0;
                  note_pos       <= note_pos + POS_W'(1);
                end
              end
              default: ;
            endcase
          end
          OP_BEEP: begin
            repeats_left   <= (beep_repeats == '0) ? REP_W'(1) : beep_repeats;
            elapsed_ms     <= '0;
            tone_limit_reg <= '0;
            if (beep_initial_gap) begin
              mode_reg      <= MODE_GAP;
              tone_active   <= 1'b0;
              tone_freq_reg <= '0;
            end else begin
              mode_reg      <= MODE_BEEP;
              tone_active   <= 1'b1;
              tone_freq_reg <= beep_frequency;
            end
          end
          OP_MELODY: begin
            tone_active    <= 1'b0;
            tone_freq_reg  <= '0;
            tone_limit_reg <= '0;
            note_pos       <= '0;
            note_wait_ms   <= '0;
            elapsed_ms     <= '0;
            mode_reg       <= MODE_MELODY;
          end
          OP_STOP: begin
            tone_active    <= 1'b0;
            tone_freq_reg  <= '0;
            tone_limit_reg <= '0;
            mode_reg       <= MODE_IDLE;
          end
          default: ;
        endcase
      end

      if (state == ST_DIV_WHOLE && div_done) begin
        whole_note_ms <= div_q;
      end
      if (state == ST_NOTE_CHECK && melody_end) begin
        tone_active    <= 1'b0;
        tone_freq_reg  <= '0;
        tone_limit_reg <= '0;
        mode_reg       <= MODE_IDLE;
      end
      if (state == ST_DIV_NOTE && div_done) begin
        note_wait_ms <= note_len;
      end
      if (state == ST_MUL && mul_done) begin
        tone_active    <= 1'b1;
        tone_freq_reg  <= note_freq;
        tone_limit_reg <= mul_p;
        elapsed_ms     <= '0;
      end

      if (ctl.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_NOTE_READ) begin
      note_freq   <= rd_entry[FREQ_W-1:0];
      note_dotted <= ndiv[NDIV_W-1];
    end
    if (ctl.out_load) begin
      m_tdata <= {1'b0,
                  (mode_reg == MODE_MELODY) ? 9'(note_pos) : 9'd0,
                  mode_reg,
                  tone_limit_reg,
                  tone_freq_reg,
                  tone_active};
    end
  end

`ifndef ASSERT_OFF
  a_tone_off_clean: assert property (@(posedge clk) disable iff (rst)
    !tone_active |-> (tone_freq_reg == '0 && tone_limit_reg == '0))
    else $error("silent tone carries frequency or limit");

  a_quiet_modes: assert property (@(posedge clk) disable iff (rst)
    (mode_reg == MODE_IDLE || mode_reg == MODE_GAP) |-> !tone_active)
    else $error("tone sounding while idle or in gap");

  a_status_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_DONE)
    else $error("status transaction raised outside completion");
`endif

endmodule

### dv/beep_and_melody_sequencer_tb.sv
`timescale 1ns / 1ps

module beep_and_melody_sequencer_tb;
  import bms_pkg::*;

  localparam int WHOLE_NOTE_NUM = 240000;
  localparam int TONE_SCALE_NUM = 58982;
  localparam int N_PHASES = 10;
  localparam int PHASE_CMDS = 20;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TAIL_CYCLES = 60;
  localparam logic [2:0] OP_RSVD_5 = 3'd5;
  localparam logic [2:0] OP_RSVD_7 = 3'd7;

  typedef struct packed {
    logic        tone_on;
    logic [15:0] freq;
    logic [18:0] limit;
    mode_t       mode;
    logic [8:0]  note;
  } status_t;

  typedef enum logic {ROW_CFG, ROW_CMD} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    cfg_idx_t    idx;
    logic [23:0] value;
    logic [2:0]  op;
    logic [7:0]  slot;
    logic [15:0] freq;
    logic [6:0]  dv;
    logic        typed;
    status_t     want;
  } plan_row_t;

  localparam status_t QUIET = '0;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [31:0]      s_tdata = '0;
  logic [2:0]       s_tuser = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [47:0]      m_tdata;
  logic             cfg_we = 1'b0;
  logic [2:0]       cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  beep_and_melody_sequencer dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // shadow registers
  logic [15:0] cf_beep_freq = '0;
  logic [23:0] cf_beep_on = '0;
  logic [23:0] cf_beep_gap = '0;
  logic [15:0] cf_repeats = 16'd1;
  logic        cf_init_gap = 1'b0;
  logic [9:0]  cf_tempo = 10'd120;
  logic [8:0]  cf_mel_len = '0;

  // sequencer state
  mode_t       sq_mode = MODE_IDLE;
  logic [23:0] sq_elapsed = '0;
  logic [15:0] sq_repeats_left = '0;
  logic [17:0] sq_whole = '0;
  logic [8:0]  sq_pos = '0;
  logic [18:0] sq_wait = '0;
  logic        sq_tone = 1'b0;
  logic [15:0] sq_freq = '0;
  logic [18:0] sq_limit = '0;
  logic [22:0] note_mem [NOTE_DEPTH];

  status_t expected_status [$];
  plan_row_t plan [$];

  int  mismatches = 0;
  int  n_cmds = 0;
  int  n_status = 0;
  int  n_writes = 0;
  int  idle_cycles = 0;
  int  stall_left = 0;
  bit  throttle_en = 1'b1;

  function automatic void silence();
    sq_tone = 1'b0;
    sq_freq = '0;
    sq_limit = '0;
  endfunction

  function automatic void sound_beep();
    sq_tone = 1'b1;
    sq_freq = cf_beep_freq;
    sq_limit = '0;
  endfunction

  function automatic void begin_note();
    logic [22:0] entry;
    logic [6:0]  dv;
    logic [6:0]  mag;
    logic [18:0] len;
    logic [63:0] prod;
    if (sq_pos >= ((cf_mel_len > 9'd256) ? 9'd256 : cf_mel_len)) begin
      silence();
      sq_mode = MODE_IDLE;
      return;
    end
    entry = note_mem[sq_pos[7:0]];
    dv = entry[22:16];
    mag = dv[6] ? -dv : dv;
    if (dv == 7'd0) begin
      len = sq_whole >> 2;
    end else begin
      len = sq_whole / mag;
      if (dv[6]) len = len + (len >> 1);
    end
    sq_wait = len;
    prod = 64'(len) * 64'(TONE_SCALE_NUM);
    sq_tone = 1'b1;
    sq_freq = entry[15:0];
    sq_limit = prod[34:16];
    sq_elapsed = '0;
  endfunction

  function automatic status_t sequence_step(logic [2:0] op, logic [7:0] slot,
                                            logic [15:0] freq, logic [6:0] dv);
    status_t s;
    case (op)
      OP_TICK: begin
        if (sq_mode != MODE_IDLE) begin
          if (sq_elapsed != 24'hFFFFFF) sq_elapsed = sq_elapsed + 24'd1;
          case (sq_mode)
            MODE_GAP: begin
              if (sq_elapsed >= cf_beep_gap) begin
                sq_mode = MODE_BEEP;
                sq_elapsed = '0;
                sound_beep();
              end
            end
            MODE_BEEP: begin
              if (sq_elapsed >= cf_beep_on) begin
                silence();
                sq_repeats_left = sq_repeats_left - 16'd1;
                if (sq_repeats_left != 16'd0) begin
                  sq_mode = MODE_GAP;
                  sq_elapsed = '0;
                end else begin
                  sq_mode = MODE_IDLE;
                end
              end
            end
            default: begin
              if (sq_elapsed >= {5'd0, sq_wait}) begin
                silence();
                sq_pos = sq_pos + 9'd1;
                begin_note();
              end
            end
          endcase
        end
      end
      OP_BEEP: begin
        silence();
        sq_repeats_left = (cf_repeats != 16'd0) ? cf_repeats : 16'd1;
        sq_elapsed = '0;
        if (cf_init_gap) begin
          sq_mode = MODE_GAP;
        end else begin
          sq_mode = MODE_BEEP;
          sound_beep();
        end
      end
      OP_MELODY: begin
        silence();
        sq_whole = 18'(WHOLE_NOTE_NUM / ((cf_tempo != 10'd0) ? cf_tempo : 10'd1));
        sq_pos = '0;
        sq_wait = '0;
        sq_elapsed = '0;
        sq_mode = MODE_MELODY;
        begin_note();
      end
      OP_STOP: begin
        silence();
        sq_mode = MODE_IDLE;
      end
      OP_WRITE: begin
        note_mem[slot] = {dv, freq};
      end
      default: begin
      end
    endcase
    s.tone_on = sq_tone;
    s.freq = sq_freq;
    s.limit = sq_limit;
    s.mode = sq_mode;
    s.note = (sq_mode == MODE_MELODY) ? sq_pos : 9'd0;
    return s;
  endfunction

  function automatic status_t st(logic t, logic [15:0] f, logic [18:0] l, mode_t m,
                                 logic [8:0] n);
    status_t s;
    s.tone_on = t;
    s.freq = f;
    s.limit = l;
    s.mode = m;
    s.note = n;
    return s;
  endfunction

  function automatic plan_row_t cfg_row(cfg_idx_t idx, logic [23:0] value);
    plan_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.value = value;
    return r;
  endfunction

  function automatic plan_row_t cmd_row(logic [2:0] op, logic [7:0] slot,
                                        logic [15:0] freq, logic [6:0] dv,
                                        logic typed, status_t want);
    plan_row_t r;
    r = '0;
    r.kind = ROW_CMD;
    r.op = op;
    r.slot = slot;
    r.freq = freq;
    r.dv = dv;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  // mostly short notes so melodies move along, sometimes anything
  function automatic logic [6:0] pick_divider();
    if ($urandom_range(0, 3) != 0) begin
      if ($urandom_range(0, 1) != 0) return 7'($urandom_range(16, 63));
      return 7'(-$urandom_range(16, 64));
    end
    return 7'($urandom);
  endfunction

  // flavor 0: all at maximum, 1: all at minimum but tempo may come out at maximum, otherwise random
  function automatic logic [23:0] pick_reg(cfg_idx_t idx, int flavor);
    int unsigned r;
    r = $urandom_range(0, 9);
    case (idx)
      CFG_BEEP_FREQ: begin
        if (flavor == 0) return 24'hFFFF;
        if (flavor == 1) return '0;
        return 24'($urandom_range(0, 65535));
      end
      CFG_BEEP_ON, CFG_BEEP_GAP: begin
        if (flavor == 0) return 24'hFFFFFF;
        if (flavor == 1 || r == 0) return '0;
        if (r == 1) return 24'hFFFFFF;
        return 24'($urandom_range(1, 6));
      end
      CFG_REPEATS: begin
        if (flavor == 0) return 24'hFFFF;
        if (flavor == 1 || r == 0) return '0;
        if (r == 1) return 24'hFFFF;
        return 24'($urandom_range(1, 4));
      end
      CFG_INIT_GAP: begin
        if (flavor == 0) return 24'd1;
        if (flavor == 1) return '0;
        return 24'($urandom_range(0, 1));
      end
      CFG_TEMPO: begin
        if (flavor == 0 || r == 0) return 24'd1023;
        if (flavor == 1) return '0;
        if (r == 1) return 24'd1;
        return 24'($urandom_range(400, 1023));
      end
      default: begin
        if (flavor == 0) return 24'd511;
        if (flavor == 1 || r == 0) return '0;
        if (r == 1) return 24'd256;
        if (r == 2) return 24'($urandom_range(257, 511));
        return 24'($urandom_range(1, 10));
      end
    endcase
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [23:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      CFG_BEEP_FREQ: cf_beep_freq = value[15:0];
      CFG_BEEP_ON:   cf_beep_on = value;
      CFG_BEEP_GAP:  cf_beep_gap = value;
      CFG_REPEATS:   cf_repeats = value[15:0];
      CFG_INIT_GAP:  cf_init_gap = value[0];
      CFG_TEMPO:     cf_tempo = value[9:0];
      CFG_MEL_LEN:   cf_mel_len = value[8:0];
      default: begin
      end
    endcase
  endtask

  task automatic issue(logic [2:0] op, logic [7:0] slot, logic [15:0] freq,
                       logic [6:0] dv, logic typed, status_t want);
    status_t predicted;
    if (throttle_en && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {1'b0, dv, freq, slot};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = sequence_step(op, slot, freq, dv);
    expected_status.push_back(typed ? want : predicted);
    n_cmds++;
    if (op == OP_WRITE) n_writes++;
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (throttle_en && $urandom_range(0, 7) == 0) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 14);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    status_t want;
    if (!rst && m_tvalid && m_tready) begin
      n_status++;
      if (expected_status.size() == 0) begin
        $error("status transaction with no command pending");
        mismatches++;
      end else begin
        want = expected_status.pop_front();
        check_field("tone_on", want.tone_on, m_tdata[0]);
        check_field("tone_frequency", want.freq, m_tdata[16:1]);
        check_field("tone_limit_ms", want.limit, m_tdata[35:17]);
        check_field("mode", want.mode, m_tdata[37:36]);
        check_field("current_note", want.note, m_tdata[46:38]);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    status_t beeping;
    bit cfg_open;
    int unsigned pick;
    logic [2:0] op;
    logic [6:0] dv;

    beeping = st(1'b1, 16'hFFFF, '0, MODE_BEEP, '0);

    plan.push_back(cmd_row(OP_TICK, 8'd0, 16'd0, 7'd0, 1'b1, QUIET));
    plan.push_back(cmd_row(OP_RSVD_5, 8'hFF, 16'hFFFF, 7'h7F, 1'b1, QUIET));
    plan.push_back(cmd_row(OP_RSVD_7, 8'd0, 16'd0, 7'd0, 1'b1, QUIET));
    // empty melody ends at once
    plan.push_back(cmd_row(OP_MELODY, 8'd0, 16'd0, 7'd0, 1'b1, QUIET));
    plan.push_back(cfg_row(CFG_BEEP_FREQ, 24'hFFFF));
    plan.push_back(cfg_row(CFG_BEEP_ON, 24'd2));
    plan.push_back(cfg_row(CFG_BEEP_GAP, 24'd1));
    plan.push_back(cfg_row(CFG_REPEATS, 24'd0));
    plan.push_back(cfg_row(CFG_INIT_GAP, 24'd1));
    // zero repeats plays one beep after the leading gap
    plan.push_back(cmd_row(OP_BEEP, 8'd0, 16'd0, 7'd0, 1'b1, st(0, 0, 0, MODE_GAP, 0)));
    plan.push_back(cmd_row(OP_TICK, 8'd0, 16'd0, 7'd0, 1'b1, beeping));
    plan.push_back(cmd_row(OP_TICK, 8'd0, 16'd0, 7'd0, 1'b1, beeping));
    plan.push_back(cmd_row(OP_TICK, 8'd0, 16'd0, 7'd0, 1'b1, QUIET));
    plan.push_back(cfg_row(CFG_REPEATS, 24'd2));
    plan.push_back(cfg_row(CFG_INIT_GAP, 24'd0));
    plan.push_back(cfg_row(CFG_BEEP_GAP, 24'd0));
    plan.push_back(cmd_row(OP_BEEP, 8'd0, 16'd0, 7'd0, 1'b1, beeping));
    plan.push_back(cmd_row(OP_TICK, 8'd0, 16'd0, 7'd0, 1'b0, QUIET));
    plan.push_back(cmd_row(OP_TICK, 8'd0, 16'd0, 7'd0, 1'b0, QUIET));
    plan.push_back(cmd_row(OP_STOP, 8'd0, 16'd0, 7'd0, 1'b1, QUIET));
    plan.push_back(cmd_row(OP_WRITE, 8'd0, 16'd0, 7'h3F, 1'b1, QUIET));
    plan.push_back(cmd_row(OP_WRITE, 8'd1, 16'd440, 7'h40, 1'b1, QUIET));
    plan.push_back(cmd_row(OP_WRITE, 8'd2, 16'd1000, 7'h7F, 1'b1, QUIET));
    plan.push_back(cmd_row(OP_WRITE, 8'd255, 16'hFFFF, 7'd0, 1'b1, QUIET));
    plan.push_back(cfg_row(CFG_TEMPO, 24'd0));
    plan.push_back(cfg_row(CFG_MEL_LEN, 24'd3));
    plan.push_back(cmd_row(OP_MELODY, 8'd0, 16'd0, 7'd0, 1'b0, QUIET));
    // beep start cuts the melody short
    plan.push_back(cmd_row(OP_BEEP, 8'd0, 16'd0, 7'd0, 1'b1, beeping));
    plan.push_back(cfg_row(CFG_TEMPO, 24'd1023));
    plan.push_back(cmd_row(OP_MELODY, 8'd0, 16'd0, 7'd0, 1'b0, QUIET));
    repeat (7) plan.push_back(cmd_row(OP_TICK, 8'd0, 16'd0, 7'd0, 1'b0, QUIET));
    plan.push_back(cmd_row(OP_STOP, 8'd0, 16'd0, 7'd0, 1'b1, QUIET));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    cfg_open = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        if (!cfg_open) drain();
        write_reg(plan[i].idx, plan[i].value);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) cfg_we <= 1'b0;
        cfg_open = 1'b0;
        issue(plan[i].op, plan[i].slot, plan[i].freq, plan[i].dv, plan[i].typed,
              plan[i].want);
      end
    end

    // load the whole note store so every melody length is legal from here on
    for (int s = 0; s < NOTE_DEPTH; s++)
      issue(OP_WRITE, 8'(s), 16'($urandom), pick_divider(), 1'b0, QUIET);

    for (int p = 0; p < N_PHASES; p++) begin
      if (p == N_PHASES - 2) throttle_en = 1'b0;
      drain();
      for (int r = 0; r < 7; r++) write_reg(cfg_idx_t'(r), pick_reg(cfg_idx_t'(r), p));
      cfg_we <= 1'b0;
      issue(($urandom_range(0, 1) != 0) ? OP_BEEP : OP_MELODY, 8'($urandom),
            16'($urandom), 7'($urandom), 1'b0, QUIET);
      repeat (PHASE_CMDS - 1) begin
        pick = $urandom_range(0, 99);
        dv = 7'($urandom);
        if (pick < 75) op = OP_TICK;
        else if (pick < 80) op = OP_STOP;
        else if (pick < 86) op = OP_BEEP;
        else if (pick < 92) op = OP_MELODY;
        else if (pick < 98) begin
          op = OP_WRITE;
          dv = pick_divider();
        end else op = 3'($urandom_range(OP_RSVD_5, OP_RSVD_7));
        issue(op, 8'($urandom), 16'($urandom), dv, 1'b0, QUIET);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_status.size() != 0) begin
      $error("%0d status transactions never arrived", expected_status.size());
      mismatches++;
    end
    $display("Sent %0d commands (%0d note store writes), checked %0d status transactions,",
             n_cmds, n_writes, n_status);
    $display("over %0d register settings with beeps, melodies, restarts and stops.",
             N_PHASES + 1);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
